@@ rtl/flrp_pkg.sv @@
// Package for the framed link receive parser: sync and type constants,
// result kind codes, the parse phase type and the structs between modules.
// Depends on nothing.
package flrp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hBC;
  localparam logic [7:0] SYNC_SECOND  = 8'hCF;
  localparam logic [7:0] TYPE_RADIO   = 8'h00;
  localparam logic [7:0] TYPE_BATTERY = 8'h13;

  // Shortest battery payload that carries the voltage word.
  localparam logic [7:0] BATTERY_MIN_LEN = 8'd5;

  localparam logic [1:0] KIND_RADIO   = 2'd0;
  localparam logic [1:0] KIND_GRANT   = 2'd1;
  localparam logic [1:0] KIND_BATTERY = 2'd2;

  typedef enum logic [6:0] {
    PH_SYNC1 = 7'b0000001,
    PH_SYNC2 = 7'b0000010,
    PH_TYPE  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CHKA  = 7'b0100000,
    PH_CHKB  = 7'b1000000
  } phase_t;

  // One validated frame waiting for the back end.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  len;
    logic [31:0] battery;
    logic        bank;
  } frame_desc_t;

  // Payload buffer write from the front end.
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] idx;
    logic [7:0] data;
  } mem_wr_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

endpackage

@@ rtl/flrp_front.sv @@
// Front end of the framed link receive parser: sync hunt, header and
// payload capture, Fletcher-style check (sums modulo 256) and frame descriptor push.
// Depends on flrp_pkg.
module flrp_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output flrp_pkg::mem_wr_t    mem_wr,
  output logic                 push,
  output flrp_pkg::frame_desc_t push_desc
);
  import flrp_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [31:0] batt_r, batt_nxt;
  logic        bank_r, bank_nxt;
  logic [7:0]  add_a;

  assign add_a = sum_a_r + rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    fill_nxt  = fill_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    batt_nxt  = batt_r;
    bank_nxt  = bank_r;
    mem_wr.en   = 1'b0;
    mem_wr.bank = bank_r;
    mem_wr.idx  = fill_r;
    mem_wr.data = rx_byte;
    push = 1'b0;
    push_desc.kind    = KIND_RADIO;
    push_desc.len     = len_r;
    push_desc.battery = batt_r;
    push_desc.bank    = bank_r;
    if (type_r == TYPE_RADIO && len_r == 8'd0) begin
      push_desc.kind = KIND_GRANT;
    end else if (type_r == TYPE_BATTERY) begin
      push_desc.kind = KIND_BATTERY;
    end
    if (accept) begin
      case (phase_r)
        PH_SYNC1: begin
          if (rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_nxt = (rx_byte == SYNC_SECOND) ? PH_TYPE : PH_SYNC1;
        end
        PH_TYPE: begin
          type_nxt  = rx_byte;
          sum_a_nxt = rx_byte;
          sum_b_nxt = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          fill_nxt  = 8'd0;
          if (rx_byte > MAX_LEN) begin
            phase_nxt = PH_SYNC1;
          end else if (rx_byte != 8'd0) begin
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_CHKA;
          end
        end
        PH_DATA: begin
          mem_wr.en = 1'b1;
          case (fill_r)
            8'd1:    batt_nxt[7:0]   = rx_byte;
            8'd2:    batt_nxt[15:8]  = rx_byte;
            8'd3:    batt_nxt[23:16] = rx_byte;
            8'd4:    batt_nxt[31:24] = rx_byte;
            default: batt_nxt = batt_r;
          endcase
          fill_nxt  = fill_r + 8'd1;
          sum_a_nxt = add_a;
          sum_b_nxt = sum_b_r + add_a;
          if (fill_nxt >= len_r) phase_nxt = PH_CHKA;
        end
        PH_CHKA: begin
          phase_nxt = (rx_byte == sum_a_r) ? PH_CHKB : PH_SYNC1;
        end
        PH_CHKB: begin
          if (rx_byte == sum_b_r) begin
            if (type_r == TYPE_RADIO ||
                (type_r == TYPE_BATTERY && len_r >= BATTERY_MIN_LEN)) begin
              push     = 1'b1;
              bank_nxt = ~bank_r;
            end
          end
          phase_nxt = PH_SYNC1;
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      type_r  <= 8'd0;
      len_r   <= 8'd0;
      fill_r  <= 8'd0;
      sum_a_r <= 8'd0;
      sum_b_r <= 8'd0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      fill_r  <= fill_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    batt_r <= batt_nxt;
  end

endmodule

@@ rtl/flrp_queue.sv @@
// Two-entry frame descriptor queue between the front and back ends.
// One entry per payload buffer bank. Depends on flrp_pkg.
module flrp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  flrp_pkg::frame_desc_t push_desc,
  input  logic                  pop,
  output flrp_pkg::frame_desc_t head,
  output flrp_pkg::queue_stat_t stat
);
  import flrp_pkg::*;

  frame_desc_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign head           = entry_r[rd_ptr_r];
  assign stat.not_empty = (count_r != 2'd0);
  assign stat.full      = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

endmodule

@@ rtl/flrp_back.sv @@
// Back end of the framed link receive parser: two-bank payload buffer and
// result sequencer that drains one queued frame at a time.
// Depends on flrp_pkg.
module flrp_back #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  flrp_pkg::mem_wr_t     mem_wr,
  input  flrp_pkg::frame_desc_t head,
  input  flrp_pkg::queue_stat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_data_byte,
  output logic [5:0]            out_byte_index,
  output logic [6:0]            out_frame_length,
  output logic [31:0]           out_battery_bits,
  output logic                  out_last
);
  import flrp_pkg::*;

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

  logic [7:0]  mem [MEM_DEPTH];
  logic [7:0]  rdata_r;

  logic [7:0]  pos_r, pos_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  pend_idx_r;
  logic [7:0]  pend_len_r;
  logic        pend_last_r;

  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  data_r;
  logic [5:0]  idx_r;
  logic [6:0]  len_r;
  logic [31:0] batt_r;
  logic        last_r;

  logic        is_last_pos;
  logic        issue;
  logic        direct;

  assign is_last_pos = (pos_r + 8'd1 == head.len);
  assign issue  = stat.not_empty && head.kind == KIND_RADIO && !pend_r && !ov_r;
  assign direct = stat.not_empty && head.kind != KIND_RADIO && !pend_r && !ov_r;
  assign pop    = direct || (issue && is_last_pos);

  always_comb begin
    pos_nxt  = pos_r;
    pend_nxt = issue;
    if (issue) pos_nxt = is_last_pos ? 8'd0 : pos_r + 8'd1;
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (pend_r || direct) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[{mem_wr.bank, mem_wr.idx[IDX_W-1:0]}] <= mem_wr.data;
    if (issue) begin
      rdata_r     <= mem[{head.bank, pos_r[IDX_W-1:0]}];
      pend_idx_r  <= pos_r;
      pend_len_r  <= head.len;
      pend_last_r <= is_last_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      kind_r <= KIND_RADIO;
      data_r <= rdata_r;
      idx_r  <= pend_idx_r[5:0];
      len_r  <= pend_len_r[6:0];
      batt_r <= 32'd0;
      last_r <= pend_last_r;
    end else if (direct) begin
      kind_r <= head.kind;
      data_r <= 8'd0;
      idx_r  <= 6'd0;
      len_r  <= (head.kind == KIND_BATTERY) ? head.len[6:0] : 7'd0;
      batt_r <= (head.kind == KIND_BATTERY) ? head.battery : 32'd0;
      last_r <= 1'b1;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = data_r;
  assign out_byte_index   = idx_r;
  assign out_frame_length = len_r;
  assign out_battery_bits = batt_r;
  assign out_last         = last_r;

endmodule

@@ rtl/framed_link_receive_parser.sv @@
// Top level of the framed link receive parser: front end, descriptor queue
// and back end with the payload buffer.
// Depends on flrp_pkg, flrp_front, flrp_queue and flrp_back.

// The parser takes one received serial byte per transaction, hunts for the
// sync pair 0xBC 0xCF, then reads type, length, payload and the two
// Fletcher-style check bytes (sums modulo 256). A radio-data frame that
// checks out is queued and yields its payload bytes as a run (or one grant
// result when it is empty), a battery frame of at least five bytes is queued
// and yields one 32-bit word, and every other frame yields nothing. Input
// bytes are taken one per cycle as long as fewer than two validated frames
// are waiting; the payload buffer has two banks, so one frame can drain
// while the next is received, and with both banks held in_stall stays high.
// Each radio payload byte passes through a buffer read, an output register
// load and then the offer of the result, because the next buffer read waits
// until the output register is empty; a grant or battery result is loaded
// straight into the output register. A result held by out_stall stays
// offered until it is taken. The output register decouples the two sides,
// so a stalled result does not stop reception until both banks are held.
module framed_link_receive_parser #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [5:0]  out_byte_index,
  output logic [6:0]  out_frame_length,
  output logic [31:0] out_battery_bits,
  output logic        out_last
);
  import flrp_pkg::*;

  mem_wr_t     mem_wr;
  logic        push;
  logic        pop;
  frame_desc_t push_desc;
  frame_desc_t head;
  queue_stat_t stat;
  logic        in_accept;

  // With both buffer banks owned by queued frames the front end must not
  // write payload, so reception waits until the back end frees one.
  assign in_stall  = stat.full;
  assign in_accept = in_valid && !in_stall;

  flrp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .rx_byte  (in_rx_byte),
    .mem_wr   (mem_wr),
    .push     (push),
    .push_desc(push_desc)
  );

  flrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  flrp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_wr          (mem_wr),
    .head            (head),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_battery_bits(out_battery_bits),
    .out_last        (out_last)
  );

  // Payload is never written into the bank that the oldest queued frame owns.
  a_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr.en && stat.not_empty) |-> (mem_wr.bank != head.bank))
    else $error("payload write into a bank still owned by a queued frame");

  // Grant and battery results always close their frame's run.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_RADIO) |-> out_last)
    else $error("grant or battery result without last");

  // A frame is never pushed while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("descriptor pushed into a full queue");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for framed_link_receive_parser: directed frames from a table,
// then random frames; its own deframer model predicts all but the hand-typed results.
// Depends on flrp_pkg and the framed_link_receive_parser RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import flrp_pkg::*;

  localparam int MAX_LEN          = 64;
  localparam int BYTE_TARGET      = 420;
  localparam int HOLD_CYCLES      = 400;
  localparam int HOLD_AFTER_BYTES = 120;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int DRAIN_CYCLES     = 300;
  localparam int MAX_REPORTS      = 40;

  // One result transaction, laid out the way the output ports carry it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic [6:0]  flen;
    logic [31:0] bits;
    logic        last;
  } link_result_t;

  // A row of the directed table: one received byte and, where the outcome is
  // obvious by hand, the single result that byte completes.
  typedef struct packed {
    logic [7:0]   rx;
    logic         typed;
    link_result_t res;
  } dir_row_t;

  // Ways a random frame can be spoiled on purpose.
  typedef enum int {FLAW_NONE, FLAW_SYNC, FLAW_LENGTH, FLAW_CHECK_A, FLAW_CHECK_B} frame_flaw_t;

  // Receiver back-pressure styles.
  typedef enum int {RX_FREE, RX_RANDOM, RX_HEAVY, RX_PERIODIC} stall_mode_t;

  localparam link_result_t NO_RESULT = '0;
  localparam link_result_t GRANT_RESULT = '{
    kind: KIND_GRANT, data: 8'h00, idx: 6'd0, flen: 7'd0, bits: 32'h0, last: 1'b1};
  localparam link_result_t BATTERY_RESULT = '{
    kind: KIND_BATTERY, data: 8'h00, idx: 6'd0, flen: 7'd5, bits: 32'h1234_5678, last: 1'b1};

  // Directed frames. Each special case of the parser appears once; the two
  // typed results were worked out by hand, everything else goes through the
  // model below.
  localparam dir_row_t DIRECTED_ROWS [41] = '{
    // A second sync byte that is 0xBC again drops the hunt; the trailing
    // 0xCF is then just noise.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT},
    // Empty radio frame: all sums stay zero, so the check bytes are 00 00.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b1, GRANT_RESULT},
    // Length byte 0xFF is far over the limit and drops the frame.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h13, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT},
    // Empty radio frame with a wrong first check byte.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    // Empty radio frame with a wrong second check byte.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    // Battery frame too short to carry a voltage word: valid, but silent.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h13, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h13, 1'b0, NO_RESULT}, '{8'h26, 1'b0, NO_RESULT},
    // Five-byte battery frame; bytes 1..4 form 0x12345678, checks D6 51.
    '{8'hBC, 1'b0, NO_RESULT}, '{8'hCF, 1'b0, NO_RESULT}, '{8'h13, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h78, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, NO_RESULT}, '{8'h34, 1'b0, NO_RESULT}, '{8'h12, 1'b0, NO_RESULT},
    '{8'hD6, 1'b0, NO_RESULT}, '{8'h51, 1'b1, BATTERY_RESULT}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [5:0]  out_byte_index;
  logic [6:0]  out_frame_length;
  logic [31:0] out_battery_bits;
  logic        out_last;

  framed_link_receive_parser #(
    .MAX_PAYLOAD(MAX_LEN)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_battery_bits(out_battery_bits),
    .out_last        (out_last)
  );

  // The clock starts low so that the first rising edge comes after every
  // process has started.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Deframer model state. It mirrors what the block should hold after every
  // accepted byte.
  phase_t       parse_ph;
  logic [7:0]   rx_frame_type;
  logic [7:0]   model_len;
  logic [6:0]   rx_fill;
  logic [7:0]   sum_a;
  logic [7:0]   sum_b;
  logic [7:0]   payload_bytes [MAX_LEN];

  link_result_t frame_results [$];   // results caused by the last byte
  link_result_t awaited_results [$]; // results the block still owes us

  int bytes_in;
  int burst_left;
  int failures;
  int reports;
  int idle_cycles;

  // Advances the deframer model by one received byte and leaves whatever
  // results that byte causes in frame_results.
  task automatic deframe_byte(input logic [7:0] b);
    link_result_t r;
    frame_results.delete();
    case (parse_ph)
      PH_SYNC1: begin
        if (b == SYNC_FIRST) parse_ph = PH_SYNC2;
      end
      PH_SYNC2: begin
        parse_ph = (b == SYNC_SECOND) ? PH_TYPE : PH_SYNC1;
      end
      PH_TYPE: begin
        rx_frame_type = b;
        sum_a = b;
        sum_b = b;
        parse_ph = PH_LEN;
      end
      PH_LEN: begin
        model_len = b;
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
        rx_fill = '0;
        if (b > MAX_LEN) parse_ph = PH_SYNC1;
        else if (b != 8'd0) parse_ph = PH_DATA;
        else parse_ph = PH_CHKA;
      end
      PH_DATA: begin
        payload_bytes[rx_fill[5:0]] = b;
        rx_fill = rx_fill + 7'd1;
        sum_a = sum_a + b;
        sum_b = sum_b + sum_a;
        if (rx_fill >= model_len) parse_ph = PH_CHKA;
      end
      PH_CHKA: begin
        parse_ph = (b == sum_a) ? PH_CHKB : PH_SYNC1;
      end
      PH_CHKB: begin
        // A frame that passes both checks is acted on right here.
        if (b == sum_b) begin
          if (rx_frame_type == TYPE_RADIO && model_len == 8'd0) begin
            r = '0;
            r.kind = KIND_GRANT;
            r.last = 1'b1;
            frame_results.push_back(r);
          end else if (rx_frame_type == TYPE_RADIO) begin
            for (int i = 0; i < model_len; i++) begin
              r = '0;
              r.kind = KIND_RADIO;
              r.data = payload_bytes[i];
              r.idx  = i[5:0];
              r.flen = model_len[6:0];
              r.last = (i == model_len - 1);
              frame_results.push_back(r);
            end
          end else if (rx_frame_type == TYPE_BATTERY && model_len >= BATTERY_MIN_LEN) begin
            r = '0;
            r.kind = KIND_BATTERY;
            r.flen = model_len[6:0];
            r.bits = {payload_bytes[4], payload_bytes[3], payload_bytes[2], payload_bytes[1]};
            r.last = 1'b1;
            frame_results.push_back(r);
          end
        end
        parse_ph = PH_SYNC1;
      end
      default: parse_ph = PH_SYNC1;
    endcase
  endtask

  // Offers one byte and waits for the transaction to complete. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap
  // (sometimes none), then a new burst length is drawn. Long bursts give
  // stretches with no idling at all.
  task automatic send_byte(input logic [7:0] b, input logic typed, input link_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_in++;
    deframe_byte(b);
    if (typed) begin
      awaited_results.push_back(res);
    end else begin
      foreach (frame_results[k]) awaited_results.push_back(frame_results[k]);
    end
  endtask

  // Sends one random frame. Most frames are well formed with random type,
  // length and payload so the parser reaches every phase; the rest carry a
  // deliberate flaw, and some are preceded by a little line noise.
  task automatic send_frame(input bit max_radio);
    frame_flaw_t flaw;
    int          pick;
    logic [7:0]  ftype;
    logic [7:0]  len;
    logic [7:0]  b;
    logic [7:0]  fa;
    logic [7:0]  fb;
    pick = $urandom_range(0, 99);
    if (max_radio || pick < 78) flaw = FLAW_NONE;
    else if (pick < 83) flaw = FLAW_SYNC;
    else if (pick < 88) flaw = FLAW_LENGTH;
    else if (pick < 94) flaw = FLAW_CHECK_A;
    else flaw = FLAW_CHECK_B;

    pick = $urandom_range(0, 9);
    if (max_radio || pick < 5) ftype = TYPE_RADIO;
    else if (pick < 8) ftype = TYPE_BATTERY;
    else ftype = 8'($urandom_range(0, 255));

    if (max_radio) len = 8'(MAX_LEN);
    else if (flaw == FLAW_LENGTH) len = 8'($urandom_range(MAX_LEN + 1, 255));
    else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, MAX_LEN));
    else len = 8'($urandom_range(0, 8));

    if (!max_radio && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
    end

    send_byte(SYNC_FIRST, 1'b0, NO_RESULT);
    if (flaw == FLAW_SYNC) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_SECOND) b = SYNC_FIRST;
      send_byte(b, 1'b0, NO_RESULT);
      return;
    end
    send_byte(SYNC_SECOND, 1'b0, NO_RESULT);
    send_byte(ftype, 1'b0, NO_RESULT);
    send_byte(len, 1'b0, NO_RESULT);
    if (flaw == FLAW_LENGTH) return;

    fa = ftype + len;
    fb = ftype + fa;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b, 1'b0, NO_RESULT);
      fa = fa + b;
      fb = fb + fa;
    end
    if (flaw == FLAW_CHECK_A) fa = fa ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CHECK_B) fb = fb ^ 8'($urandom_range(1, 255));
    send_byte(fa, 1'b0, NO_RESULT);
    send_byte(fb, 1'b0, NO_RESULT);
  endtask

  // Stimulus: reset once, the directed table, then random frames. The first
  // random frame is always a full-size radio frame.
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    parse_ph      = PH_SYNC1;
    rx_frame_type = '0;
    model_len     = '0;
    rx_fill       = '0;
    sum_a         = '0;
    sum_b         = '0;
    bytes_in      = 0;
    burst_left    = 0;
    failures      = 0;
    reports       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[k]) begin
      send_byte(DIRECTED_ROWS[k].rx, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);
    end

    send_frame(1'b1);
    while (bytes_in < BYTE_TARGET) send_frame(1'b0);

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // Anything the block emits after this point has no expectation and is
    // flagged by the result checker.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: a back-pressure mode is drawn for each stretch of cycles. Once
  // enough bytes are in, it holds stall high for a long stretch while the
  // sender keeps going, so both payload banks fill and in_stall rises.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int          tick;
    bit          held;
    mode = RX_FREE;
    span = 0;
    tick = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && bytes_in >= HOLD_AFTER_BYTES) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 100);
        end
        span--;
        tick++;
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_RANDOM:   out_stall <= 1'($urandom_range(0, 1));
          RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_stall <= ((tick % 5) < 2);
          default:     out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      reports++;
      if (reports <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Result checker: every accepted result transaction is matched against the
  // oldest outstanding expectation, field by field.
  always @(posedge clk) begin
    link_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h index %0d",
                   $time, out_kind, out_data_byte, out_byte_index);
        end
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("data_byte", 32'(want.data), 32'(out_data_byte));
        check_field("byte_index", 32'(want.idx), 32'(out_byte_index));
        check_field("frame_length", 32'(want.flen), 32'(out_frame_length));
        check_field("battery_bits", want.bits, out_battery_bits);
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Watchdog: a long run of cycles without any transaction on either side
  // means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

@@ files.f @@
rtl/flrp_pkg.sv
rtl/flrp_front.sv
rtl/flrp_queue.sv
rtl/flrp_back.sv
rtl/framed_link_receive_parser.sv
tb/tb_top.sv
